>>> rtl/nearest_palette_index_defines.svh
// Assertion macros used by the palette matcher RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope for NPI_ASSERT.
`ifndef NEAREST_PALETTE_INDEX_DEFINES_SVH
`define NEAREST_PALETTE_INDEX_DEFINES_SVH

// Generic clocked assertion with active-low reset disable.
`define NPI_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define NPI_ASSERT(lbl, prop, msg) \
  `NPI_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/npi_pkg.sv
// Shared types and constants for the nearest palette index matcher.
// No dependencies.
package npi_pkg;

  localparam int PaletteDepthDef = 256;
  localparam int DistW           = 18;   // 4 * 255^2 fits in 18 bits
  localparam int SqW             = 16;
  localparam logic [7:0] AlphaOpaqueMin = 8'd128;
  localparam logic [DistW-1:0] DistInit = '1;

  // One beat travelling down the cell chain: a pixel or a palette write.
  typedef struct packed {
    logic             wr;
    logic [31:0]      data;      // pixel for a lookup, color for a write
    logic [7:0]       slot;
    logic [7:0]       best_idx;
    logic [DistW-1:0] best_dist;
  } npi_beat_t;

endpackage

>>> rtl/npi_if.sv
// Valid/ready channel interfaces for palette requests and index results.
// No dependencies.
interface npi_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] pixel_argb;
  logic [7:0]  entry_index;
  logic [31:0] entry_color;

  modport source (output valid, req_type, pixel_argb, entry_index, entry_color,
                  input ready);
  modport sink   (input valid, req_type, pixel_argb, entry_index, entry_color,
                  output ready);
endinterface

interface npi_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (output valid, color_index, input ready);
  modport sink   (input valid, color_index, output ready);
endinterface

>>> rtl/npi_cell.sv
// One palette cell: holds one entry, squares the channel differences, then
// folds the distance into the running best. Depends on npi_pkg.
module npi_cell #(
  parameter int CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [8:0]        n_used_i,
  input  logic              vld_i,
  input  npi_pkg::npi_beat_t beat_i,
  output logic              vld_o,
  output npi_pkg::npi_beat_t beat_o
);
  import npi_pkg::*;

  localparam logic [7:0] CellSlot = 8'(CellIdx);
  localparam logic [8:0] CellPos  = 9'(CellIdx);

  logic [31:0]               entry_q;
  logic                      s1_vld_q;
  npi_beat_t                 s1_q;
  logic [3:0][SqW-1:0]       sq_d, sq_q;
  logic                      s2_vld_q;
  npi_beat_t                 s2_d, s2_q;
  logic [DistW-1:0]          dist_sum;
  logic                      take;

  // Stage 1: absolute byte differences squared.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [7:0] x, y, d;
      x = beat_i.data[8*b +: 8];
      y = entry_q[8*b +: 8];
      d = (x > y) ? (x - y) : (y - x);
      sq_d[b] = SqW'(d) * SqW'(d);
    end
  end

  // Capture a write beat addressed to this cell.
  always_ff @(posedge clk_i) begin
    if (en_i && vld_i && beat_i.wr && (beat_i.slot == CellSlot)) begin
      entry_q <= beat_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= beat_i;
      sq_q <= sq_d;
      s2_q <= s2_d;
    end
  end

  // Stage 2: sum and compare; strict less keeps the lower index on a tie.
  always_comb begin
    dist_sum = DistW'(sq_q[0]) + DistW'(sq_q[1]) + DistW'(sq_q[2]) + DistW'(sq_q[3]);
    take = !s1_q.wr && (CellPos < n_used_i) && (dist_sum < s1_q.best_dist);
    s2_d = s1_q;
    if (take) begin
      s2_d.best_dist = dist_sum;
      s2_d.best_idx  = CellSlot;
    end
  end

  assign vld_o  = s2_vld_q;
  assign beat_o = s2_q;

endmodule

>>> rtl/nearest_palette_index.sv
// Top level of the nearest palette index matcher: config register, cell
// chain and output register. Depends on npi_pkg, npi_if, npi_cell and
// nearest_palette_index_defines.svh.
//
// Usage:
//   req_i carries beats of two kinds. req_type 1 writes entry_color into
//   palette slot entry_index (slots at or above PALETTE_DEPTH are dropped)
//   and yields no result. req_type 0 maps pixel_argb to a palette index
//   delivered on rsp_o.
//   cfg_we_i / cfg_wdata_i set palette_size while the block is idle; 0 acts
//   as 1 and values above PALETTE_DEPTH act as PALETTE_DEPTH.
//   Both kinds of beat travel down a chain of PALETTE_DEPTH cells, two
//   register stages per cell, so writes and pixels keep their order.
//   A beat passes both registers of every cell and then the output register
//   before rsp_o.valid. Throughput: one beat per cycle unless rsp_o stalls.
//   When rsp_o is stalled with a result held, the whole chain holds and
//   req_i.ready drops. Reset empties the chain and sets palette_size to 1;
//   palette contents are undefined until written.
`include "nearest_palette_index_defines.svh"

module nearest_palette_index #(
  parameter int PALETTE_DEPTH = npi_pkg::PaletteDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  npi_req_if.sink    req_i,
  npi_rsp_if.source  rsp_o
);
  import npi_pkg::*;

  localparam logic [8:0] DepthW = 9'(PALETTE_DEPTH);

  logic [8:0]  palette_size_q;
  logic [8:0]  n_used;
  logic [7:0]  last_idx;
  logic        en;
  logic        out_vld_q;
  logic        out_vld_d;
  logic [7:0]  out_idx_q, out_idx_d;

  logic      chain_vld  [PALETTE_DEPTH+1];
  npi_beat_t chain_beat [PALETTE_DEPTH+1];

  logic      tail_vld;
  npi_beat_t tail_beat;
  logic      stall_tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= 9'd1;
    end else if (cfg_we_i) begin
      palette_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (palette_size_q == 9'd0) begin
      n_used = 9'd1;
    end else if (palette_size_q > DepthW) begin
      n_used = DepthW;
    end else begin
      n_used = palette_size_q;
    end
    last_idx = 8'(n_used - 9'd1);
  end

  // Advance the chain whenever the output slot is free or being drained.
  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  always_comb begin
    chain_vld[0]            = req_i.valid;
    chain_beat[0].wr        = req_i.req_type;
    chain_beat[0].data      = req_i.req_type ? req_i.entry_color : req_i.pixel_argb;
    chain_beat[0].slot      = req_i.entry_index;
    chain_beat[0].best_idx  = 8'd0;
    chain_beat[0].best_dist = DistInit;
  end

  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
    npi_cell #(
      .CellIdx (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .n_used_i (n_used),
      .vld_i    (chain_vld[g]),
      .beat_i   (chain_beat[g]),
      .vld_o    (chain_vld[g+1]),
      .beat_o   (chain_beat[g+1])
    );
  end

  assign tail_vld   = chain_vld[PALETTE_DEPTH];
  assign tail_beat  = chain_beat[PALETTE_DEPTH];
  assign stall_tail = !en && tail_vld;

  // Drop write beats at the end of the chain; low alpha maps to the last slot.
  always_comb begin
    out_vld_d = tail_vld && !tail_beat.wr;
    if (tail_beat.data[31:24] < AlphaOpaqueMin) begin
      out_idx_d = last_idx;
    end else begin
      out_idx_d = tail_beat.best_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_idx_q <= out_idx_d;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.color_index = out_idx_q;

  `NPI_ASSERT(a_stall_holds_chain, stall_tail |=> (tail_vld && $stable(tail_beat)), "chain moved")
  `NPI_ASSERT(a_pixel_found_entry, out_vld_d |-> (tail_beat.best_dist != DistInit), "no match")
  `NPI_ASSERT(a_write_no_result, (en && tail_vld && tail_beat.wr) |=> !out_vld_q, "write result")

endmodule

>>> bench/nearest_palette_index_tb.sv
// Self-checking bench for nearest_palette_index: directed table, then random phases over
// several palette sizes; lookups match table values or a local nearest-color search.
// Depends on npi_pkg, npi_if (npi_req_if, npi_rsp_if) and the nearest_palette_index RTL.
`timescale 1ns / 100ps

module nearest_palette_index_tb;

  localparam int PaletteSlots = 256;
  localparam int AlphaCutoff  = 128;
  localparam int DrainCycles  = 2 * PaletteSlots + 1 + 16;
  localparam int ItemGoal     = 1650;
  localparam int PhaseItems   = 150;
  localparam int CycleLimit   = 1_000_000;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL, ROW_SIZE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] argb;     // pixel or entry color
    logic [8:0]  arg;      // slot or palette size
    bit          has_exp;
    logic [7:0]  exp_idx;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [8:0] cfg_wdata_i;

  npi_req_if req_if ();
  npi_rsp_if rsp_if ();

  nearest_palette_index u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the palette and size register
  logic [31:0] pal_color [PaletteSlots];
  bit          slot_written [PaletteSlots];
  logic [8:0]  pal_size;

  logic [7:0]  idx_pending [$];
  dir_row_t    dir_rows [$];

  bit calm;
  int errors;
  int n_lookups;
  int n_writes;
  int n_results;
  int n_sizes;
  int cycle_count;

  function automatic int eff_size(input logic [8:0] v);
    if (v < 9'd1) return 1;
    if (v > 9'(PaletteSlots)) return PaletteSlots;
    return int'(v);
  endfunction

  function automatic logic [7:0] nearest_slot(input logic [31:0] px);
    int          n;
    int          best;
    int          dx;
    int unsigned sum_sq;
    int unsigned best_dist;
    n = eff_size(pal_size);
    if (int'(px[31:24]) < AlphaCutoff) return 8'(n - 1);
    best = 0;
    best_dist = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      sum_sq = 0;
      for (int b = 0; b < 4; b++) begin
        dx = int'(px[8*b +: 8]) - int'(pal_color[i][8*b +: 8]);
        sum_sq += dx * dx;
      end
      // strict compare keeps the lower index on a tie
      if (sum_sq < best_dist) begin
        best_dist = sum_sq;
        best = i;
      end
    end
    return 8'(best);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] coarse_color();
    logic [7:0]  levels [5];
    logic [31:0] c;
    levels = '{8'h00, 8'h40, 8'h7F, 8'h80, 8'hFF};
    for (int b = 0; b < 4; b++) c[8*b +: 8] = levels[$urandom_range(0, 4)];
    return c;
  endfunction

  function automatic logic [31:0] make_color();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return coarse_color();
  endfunction

  function automatic logic [31:0] make_pixel(input int n);
    int          r;
    logic [31:0] px;
    r = $urandom_range(0, 9);
    px = $urandom;
    if (r >= 3 && r <= 5) begin
      // land near a live entry so small distances and ties show up
      px = pal_color[$urandom_range(0, n - 1)] ^ ($urandom & 32'h0303_0303);
    end else if (r <= 7 && r > 5) begin
      px = coarse_color();
    end else if (r == 8) begin
      px[31:24] = 8'($urandom_range(0, AlphaCutoff - 1));
    end else if (r == 9) begin
      px[31:24] = 8'($urandom_range(AlphaCutoff - 1, AlphaCutoff));
    end
    return px;
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [31:0] argb, input logic [8:0] arg,
                         input bit has_exp, input logic [7:0] exp_idx);
    dir_row_t row;
    row.kind = kind;
    row.argb = argb;
    row.arg = arg;
    row.has_exp = has_exp;
    row.exp_idx = exp_idx;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Call at a falling edge; returns at a falling edge with valid possibly still high.
  task automatic send_beat(input bit is_wr, input logic [31:0] px, input logic [7:0] slot,
                           input logic [31:0] col, input bit has_exp, input logic [7:0] exp_idx);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.req_type = is_wr ? REQ_WRITE : REQ_PIXEL;
    req_if.pixel_argb = px;
    req_if.entry_index = slot;
    req_if.entry_color = col;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (is_wr) begin
      pal_color[slot] = col;
      slot_written[slot] = 1'b1;
      n_writes++;
    end else begin
      idx_pending.insert(idx_pending.size(), has_exp ? exp_idx : nearest_slot(px));
      n_lookups++;
    end
    @(negedge clk_i);
  endtask

  // Writes leave nothing pending, so sit out a full pipeline after the last result.
  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (idx_pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_palette_size(input logic [8:0] v);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    pal_size = v;
    n_sizes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Receiver: random back-pressure with calm stretches
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        hold_left = calm ? 0 : pick_gap();
        rsp_if.ready = (hold_left == 0);
        if (hold_left != 0) hold_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [7:0] exp_idx;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      n_results++;
      if (idx_pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected color_index %0d with nothing pending", $time,
                 rsp_if.color_index);
      end else begin
        exp_idx = idx_pending.pop_front();
        if (rsp_if.color_index !== exp_idx) begin
          errors++;
          $display("%0t: color_index mismatch, expected %0d got %0d", $time, exp_idx,
                   rsp_if.color_index);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, idx_pending.size());
      $display("** nearest_palette_index: FAILED **");
      $finish;
    end
  end

  initial begin
    int          size_plan [8];
    int          v;
    int          n;
    int          phase;
    dir_row_t    row;

    req_if.valid = 1'b0;
    req_if.req_type = REQ_PIXEL;
    req_if.pixel_argb = '0;
    req_if.entry_index = '0;
    req_if.entry_color = '0;
    rsp_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    pal_size = 9'd1;
    calm = 1'b0;
    for (int i = 0; i < PaletteSlots; i++) begin
      pal_color[i] = '0;
      slot_written[i] = 1'b0;
    end

    // Transparent black in slot 0 before any lookup
    add_row(ROW_WRITE, 32'h0000_0000, 9'd0, 1'b0, 8'd0);
    add_row(ROW_PIXEL, 32'h00FF_FFFF, 9'd0, 1'b1, 8'd0);
    add_row(ROW_PIXEL, 32'hFFFF_FFFF, 9'd0, 1'b1, 8'd0);
    add_row(ROW_SIZE,  32'h0,         9'd0, 1'b0, 8'd0);   // zero acts as one
    add_row(ROW_PIXEL, 32'h7FFF_FFFF, 9'd0, 1'b1, 8'd0);
    add_row(ROW_PIXEL, 32'h8000_0000, 9'd0, 1'b1, 8'd0);
    add_row(ROW_WRITE, 32'hFFFF_FFFF, 9'd1, 1'b0, 8'd0);
    add_row(ROW_WRITE, 32'hFF00_0000, 9'd2, 1'b0, 8'd0);
    add_row(ROW_WRITE, 32'h8080_8080, 9'd3, 1'b0, 8'd0);
    add_row(ROW_WRITE, 32'hFF00_0002, 9'd4, 1'b0, 8'd0);
    add_row(ROW_SIZE,  32'h0,         9'd5, 1'b0, 8'd0);
    add_row(ROW_PIXEL, 32'h7F00_0000, 9'd0, 1'b1, 8'd4);
    add_row(ROW_PIXEL, 32'hFFFF_FFFF, 9'd0, 1'b1, 8'd1);
    add_row(ROW_PIXEL, 32'h8080_8080, 9'd0, 1'b1, 8'd3);
    add_row(ROW_PIXEL, 32'hFF00_0001, 9'd0, 1'b1, 8'd2);   // equal distance to 2 and 4
    add_row(ROW_PIXEL, 32'h0000_0000, 9'd0, 1'b1, 8'd4);
    add_row(ROW_PIXEL, 32'h8000_0000, 9'd0, 1'b0, 8'd0);
    add_row(ROW_PIXEL, 32'hC040_4040, 9'd0, 1'b0, 8'd0);
    add_row(ROW_WRITE, 32'hFFFF_FFFF, 9'd0, 1'b0, 8'd0);
    add_row(ROW_PIXEL, 32'hFFFF_FFFF, 9'd0, 1'b1, 8'd0);   // exact tie, lower slot
    add_row(ROW_WRITE, 32'h1234_5678, 9'd255, 1'b0, 8'd0); // outside the live range
    add_row(ROW_PIXEL, 32'h1234_5678, 9'd0, 1'b0, 8'd0);
    add_row(ROW_SIZE,  32'h0,         9'd2, 1'b0, 8'd0);
    add_row(ROW_PIXEL, 32'h80FF_00FF, 9'd0, 1'b0, 8'd0);
    add_row(ROW_PIXEL, 32'h7E00_0000, 9'd0, 1'b1, 8'd1);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_SIZE: begin
          set_palette_size(row.arg);
        end
        ROW_WRITE: begin
          send_beat(1'b1, $urandom, row.arg[7:0], row.argb, 1'b0, 8'd0);
        end
        default: begin
          send_beat(1'b0, row.argb, 8'($urandom), $urandom, row.has_exp, row.exp_idx);
        end
      endcase
    end

    // Random phases: a size per phase, fill any live slot still blank, then mixed traffic
    size_plan = '{256, 1, 511, 3, 0, 257, 2, 128};
    phase = 0;
    while (n_lookups + n_writes < ItemGoal) begin
      v = (phase < 8) ? size_plan[phase] : $urandom_range(0, 511);
      calm = (phase % 4 == 3);
      set_palette_size(9'(v));
      n = eff_size(9'(v));
      for (int s = 0; s < n; s++) begin
        if (!slot_written[s]) send_beat(1'b1, $urandom, 8'(s), make_color(), 1'b0, 8'd0);
      end
      repeat (PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          send_beat(1'b1, $urandom, 8'($urandom_range(0, 255)), make_color(), 1'b0, 8'd0);
        end else begin
          send_beat(1'b0, make_pixel(n), 8'($urandom), $urandom, 1'b0, 8'd0);
        end
      end
      phase++;
    end

    calm = 1'b0;
    wait_idle();
    $display("Covered %0d lookups and %0d palette writes across %0d size settings.",
             n_lookups, n_writes, n_sizes);
    $display("Checked %0d results, %0d mismatches, %0d left pending.",
             n_results, errors, idx_pending.size());
    if (errors == 0 && idx_pending.size() == 0) begin
      $display("** nearest_palette_index: PASSED **");
    end else begin
      $display("** nearest_palette_index: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/npi_pkg.sv
rtl/npi_if.sv
rtl/npi_cell.sv
rtl/nearest_palette_index.sv
bench/nearest_palette_index_tb.sv
